>>> rtl/core/uvc_pkg.sv
// uvc_pkg: shared types, error codes and limits for the UTF-8 validate/count block.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package uvc_pkg;

  localparam int unsigned MAX_STRING_BYTES = 32'd65535;

  // Offsets at or beyond this value are "too long"; never more than the 16-bit offset range.
  localparam logic [15:0] LIMIT_BYTES =
    (MAX_STRING_BYTES > 32'd65535) ? 16'hFFFF : MAX_STRING_BYTES[15:0];

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Word index of the start limit register and its byte address.
  localparam int unsigned REG_START_LIMIT = 0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_START_LIMIT = CFG_ADDR_W'(REG_START_LIMIT * 4);

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_STRAY   = 3'd1,
    ERR_EARLY   = 3'd2,
    ERR_BADLEAD = 3'd3,
    ERR_TRUNC   = 3'd4,
    ERR_FULL    = 3'd5,
    ERR_LONG    = 3'd6
  } uvc_err_t;

  typedef struct packed {
    logic        start_mark;
    logic [15:0] byte_offset;
    logic [15:0] ascii_total;
    logic [15:0] multibyte_total;
    logic [15:0] char_total;
    uvc_err_t    error_code;
    logic        string_done;
  } uvc_result_t;

endpackage

`default_nettype wire

>>> rtl/core/uvc_in_if.sv
// uvc_in_if: valid/ready channel carrying one string byte and its last flag per word.
// Depends on nothing.
`default_nettype none

interface uvc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/uvc_out_if.sv
// uvc_out_if: valid/ready channel carrying one per-byte result word.
// Depends on nothing.
`default_nettype none

interface uvc_out_if;
  logic        valid;
  logic        ready;
  logic        start_mark;
  logic [15:0] byte_offset;
  logic [15:0] ascii_total;
  logic [15:0] multibyte_total;
  logic [15:0] char_total;
  logic [2:0]  error_code;
  logic        string_done;

  modport source (output valid, output start_mark, output byte_offset, output ascii_total,
                  output multibyte_total, output char_total, output error_code,
                  output string_done, input ready);
  modport sink   (input valid, input start_mark, input byte_offset, input ascii_total,
                  input multibyte_total, input char_total, input error_code,
                  input string_done, output ready);
endinterface

`default_nettype wire

>>> rtl/core/utf8_validate_count_top.sv
// utf8_validate_count_top: streaming UTF-8 structure checker and character counter.
// Uses uvc_pkg, uvc_in_if, uvc_out_if, uvc_cfg, uvc_step and uvc_out_stage.
// Result words are registered, in the skid register if the output stalls. Throughput: one byte
// per cycle while skid is empty; the byte check is one pass between state and output registers.
// Reset (rst_n, synchronous, low): clears string state, start limit and output valids.
`default_nettype none

module utf8_validate_count_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  uvc_in_if.sink                              in_ch,
  uvc_out_if.source                           out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [uvc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [uvc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [uvc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);

  logic                 in_fire;
  logic                 can_push;
  logic [15:0]          start_limit;
  uvc_pkg::uvc_result_t step_word;
  uvc_pkg::uvc_result_t out_word;

  // Input is held off only when both the output and skid registers are full.
  assign in_ch.ready = can_push;
  assign in_fire     = in_ch.valid & can_push;

  uvc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .start_limit (start_limit)
  );

  // State advances on every accepted byte word; the result word is built in the same pass.
  uvc_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .data_byte   (in_ch.data_byte),
    .last_byte   (in_ch.last_byte),
    .start_limit (start_limit),
    .result      (step_word)
  );

  uvc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_word (step_word),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  // Unpack the result word onto the channel fields.
  assign out_ch.start_mark      = out_word.start_mark;
  assign out_ch.byte_offset     = out_word.byte_offset;
  assign out_ch.ascii_total     = out_word.ascii_total;
  assign out_ch.multibyte_total = out_word.multibyte_total;
  assign out_ch.char_total      = out_word.char_total;
  assign out_ch.error_code      = out_word.error_code;
  assign out_ch.string_done     = out_word.string_done;

endmodule

`default_nettype wire

>>> rtl/core/uvc_cfg.sv
// uvc_cfg: APB-style register port holding the start limit.
// Depends on uvc_pkg.
`default_nettype none

module uvc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [uvc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [uvc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [uvc_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                  cfg_pready,
  output logic      [15:0]                      start_limit
);

  logic [15:0] start_limit_r;
  logic [15:0] start_limit_nxt;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite
                    & (cfg_paddr == uvc_pkg::ADDR_START_LIMIT);

  always_comb begin
    start_limit_nxt = start_limit_r;
    if (wr_en) begin
      start_limit_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_limit_r <= 16'd0;
    end else begin
      start_limit_r <= start_limit_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == uvc_pkg::ADDR_START_LIMIT) begin
      cfg_prdata = {{(uvc_pkg::CFG_DATA_W-16){1'b0}}, start_limit_r};
    end
  end

  assign start_limit = start_limit_r;

endmodule

`default_nettype wire

>>> rtl/core/uvc_step.sv
// uvc_step: per-string state and the single-pass byte check that yields one result word.
// Depends on uvc_pkg.
`default_nettype none

module uvc_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 last_byte,
  input  wire logic [15:0]          start_limit,
  output uvc_pkg::uvc_result_t      result
);

  logic [1:0]        pend_r,   pend_nxt;
  logic [15:0]       pos_r,    pos_nxt;
  logic [15:0]       ascii_r,  ascii_nxt;
  logic [15:0]       mb_r,     mb_nxt;
  logic [15:0]       starts_r, starts_nxt;
  uvc_pkg::uvc_err_t err_r,    err_nxt;

  uvc_pkg::uvc_err_t err;
  logic [1:0]        pend;
  logic [15:0]       asc;
  logic [15:0]       mb;
  logic              is_start;
  logic              mark;

  always_comb begin
    err        = uvc_pkg::ERR_NONE;
    pend       = pend_r;
    asc        = ascii_r;
    mb         = mb_r;
    is_start   = 1'b0;
    mark       = 1'b0;
    pend_nxt   = pend_r;
    ascii_nxt  = ascii_r;
    mb_nxt     = mb_r;
    starts_nxt = starts_r;
    err_nxt    = err_r;

    if (err_r == uvc_pkg::ERR_NONE) begin
      // classify the byte by its leading ones
      if (pos_r >= uvc_pkg::LIMIT_BYTES) begin
        err = uvc_pkg::ERR_LONG;
      end else if (!data_byte[7]) begin
        if (pend_r != 2'd0) err = uvc_pkg::ERR_EARLY;
        else begin
          asc      = ascii_r + 16'd1;
          is_start = 1'b1;
        end
      end else if (!data_byte[6]) begin
        if (pend_r == 2'd0) err = uvc_pkg::ERR_STRAY;
        else begin
          pend = pend_r - 2'd1;
          if (pend_r == 2'd1) mb = mb_r + 16'd1;
        end
      end else if (!data_byte[5]) begin
        if (pend_r != 2'd0) err = uvc_pkg::ERR_EARLY;
        else begin
          pend     = 2'd1;
          is_start = 1'b1;
        end
      end else if (!data_byte[4]) begin
        if (pend_r != 2'd0) err = uvc_pkg::ERR_EARLY;
        else begin
          pend     = 2'd2;
          is_start = 1'b1;
        end
      end else if (!data_byte[3]) begin
        if (pend_r != 2'd0) err = uvc_pkg::ERR_EARLY;
        else begin
          pend     = 2'd3;
          is_start = 1'b1;
        end
      end else begin
        err = uvc_pkg::ERR_BADLEAD;
      end

      if ((err == uvc_pkg::ERR_NONE) && is_start && (start_limit != 16'd0)) begin
        if (starts_r >= start_limit) err = uvc_pkg::ERR_FULL;
        else mark = 1'b1;
      end

      if (err == uvc_pkg::ERR_NONE) begin
        pend_nxt  = pend;
        ascii_nxt = asc;
        mb_nxt    = mb;
        if (mark) starts_nxt = starts_r + 16'd1;
        if (last_byte && (pend != 2'd0)) err = uvc_pkg::ERR_TRUNC;
      end else begin
        mark = 1'b0;
      end
      err_nxt = err;
    end

    pos_nxt = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;
  end

  always_comb begin
    result.start_mark      = mark;
    result.byte_offset     = pos_r;
    result.ascii_total     = ascii_nxt;
    result.multibyte_total = mb_nxt;
    result.char_total      = ascii_nxt + mb_nxt;
    result.error_code      = err_nxt;
    result.string_done     = last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 2'd0;
      pos_r    <= 16'd0;
      ascii_r  <= 16'd0;
      mb_r     <= 16'd0;
      starts_r <= 16'd0;
      err_r    <= uvc_pkg::ERR_NONE;
    end else if (accept) begin
      if (last_byte) begin
        // end of string: start clean for the next one
        pend_r   <= 2'd0;
        pos_r    <= 16'd0;
        ascii_r  <= 16'd0;
        mb_r     <= 16'd0;
        starts_r <= 16'd0;
        err_r    <= uvc_pkg::ERR_NONE;
      end else begin
        pend_r   <= pend_nxt;
        pos_r    <= pos_nxt;
        ascii_r  <= ascii_nxt;
        mb_r     <= mb_nxt;
        starts_r <= starts_nxt;
        err_r    <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/uvc_out_stage.sv
// uvc_out_stage: output register plus skid register between the step logic and the result channel.
// Depends on uvc_pkg.
`default_nettype none

module uvc_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire uvc_pkg::uvc_result_t push_word,
  output logic                      can_push,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output uvc_pkg::uvc_result_t      out_word
);

  logic                 out_v_r,  out_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  uvc_pkg::uvc_result_t out_r,    out_nxt;
  uvc_pkg::uvc_result_t skid_r,   skid_nxt;
  logic                 out_fire;

  assign out_fire = out_v_r & out_ready;
  assign can_push = ~skid_v_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (out_fire) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || out_fire) begin
        out_nxt   = push_word;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_word;
        skid_v_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule

`default_nettype wire
